FILE: hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared sizes, the page record layout, status codes and init helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MAX_ORDER = 12;
    localparam int NUM_ORD   = MAX_ORDER + 1;
    localparam int ORD_W     = 4;
    localparam int PAGE_W    = 12;
    localparam int NPAGES    = 1 << PAGE_W;
    localparam int LINK_W    = PAGE_W + 1;
    localparam int CNT_W     = 13;
    localparam int TOT_W     = 26;

    localparam logic [LINK_W-1:0] LINK_NONE   = '1;
    localparam logic [CNT_W-1:0]  ARENA_RESET = 13'd4096;
    localparam logic [CNT_W-1:0]  PAGE_CAP    = 13'd4096;
    localparam logic [12:0]       TOTAL_SAT   = 13'd8191;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_BIG   = 2'd2,
        ST_NOMEM = 2'd3
    } t_status;

    typedef struct packed {
        logic              free_head;
        logic [ORD_W-1:0]  order;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_rec;

    localparam t_rec REC_EMPTY = '{free_head: 1'b0, order: '0,
                                   next: LINK_NONE, prev: LINK_NONE};

    // Smallest k with 2^k >= n; n of zero gives zero.
    function automatic logic [ORD_W-1:0] f_ceil_log2(input logic [12:0] n);
        logic [ORD_W-1:0] r;
        r = ORD_W'(13);
        for (int k = 13; k >= 0; k--) begin
            if ((14'd1 << k) >= {1'b0, n}) begin
                r = ORD_W'(k);
            end
        end
        return r;
    endfunction

    // Start page of the initial block of order k, or none. The greedy split puts
    // one block per set bit of the arena size, largest first.
    function automatic logic [LINK_W-1:0] f_init_head(input logic [12:0] arena,
                                                      input int k);
        logic [13:0] m;
        m = (14'd2 << k) - 14'd1;
        if (arena[k]) begin
            return arena & ~m[12:0];
        end
        return LINK_NONE;
    endfunction

    function automatic t_rec f_init_rec(input logic [12:0] arena,
                                        input logic [PAGE_W-1:0] page);
        t_rec r;
        r = REC_EMPTY;
        for (int k = 0; k < NUM_ORD; k++) begin
            if (arena[k] && ({1'b0, page} == f_init_head(arena, k))) begin
                r.free_head = 1'b1;
                r.order     = ORD_W'(k);
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator
// Per-order LIFO free lists over a page arena, kept in one page record memory.
// ----------------------------------------------------------------------------
// Usage. A request is transferred when start is high while busy is low; it
// carries i_func (0 allocate, 1 free), i_page_count and i_block_start. Exactly
// one result follows, shown for a single cycle with o_strobe high: o_status,
// o_granted_start and o_free_page_total. The receiver cannot stall it, so a
// result is lost if not sampled in that cycle. busy stays high from the
// transfer until the cycle after the strobe.
// Operation. Each request runs as a sequence of memory read and write steps on
// the page record memory. A request rejected on its count goes straight to the
// result; one refused by the list or arena check passes the check state first.
// An unlink reads the page record, then rewrites the previous and next links
// and clears the page; a push reads and checks the page record, unlinks it
// first when it is already listed, then writes it and the old head's link.
// An allocate splits the found block down the orders; a free merges buddies.
// Reset and configuration. After reset, and after every transfer on the
// configuration channel (i_cfg_valid, o_cfg_ready is always high), the block
// sweeps all 4096 page records once, one per cycle, writing the initial free
// lists; busy is high throughout the sweep. Arena sizes above 4096 are
// clamped to 4096.
// ----------------------------------------------------------------------------
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_func,
    input  logic [12:0]       i_page_count,
    input  logic [11:0]       i_block_start,
    output logic              o_strobe,
    output logic [1:0]        o_status,
    output logic [11:0]       o_granted_start,
    output logic [12:0]       o_free_page_total,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [12:0]       i_cfg_data
);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_CHK    = 15'b000000000000100,
        S_U_RD   = 15'b000000000001000,
        S_U_W1   = 15'b000000000010000,
        S_U_W2   = 15'b000000000100000,
        S_U_W3   = 15'b000000001000000,
        S_SPLIT  = 15'b000000010000000,
        S_P_RD   = 15'b000000100000000,
        S_P_CHK  = 15'b000001000000000,
        S_P_W1   = 15'b000010000000000,
        S_P_W2   = 15'b000100000000000,
        S_F_CHK  = 15'b001000000000000,
        S_F_EVAL = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    // Where an unlink or a push resumes once it is finished.
    typedef enum logic [1:0] {
        UR_ALLOC = 2'd0,
        UR_FREE  = 2'd1,
        UR_PUSH  = 2'd2
    } t_uret;

    typedef enum logic {
        PR_SPLIT = 1'b0,
        PR_DONE  = 1'b1
    } t_pret;

    t_state              r_state, n_state;
    logic [12:0]         r_arena, n_arena;
    logic [PAGE_W-1:0]   r_clr, n_clr;
    logic [LINK_W-1:0]   r_head [NUM_ORD];
    logic [LINK_W-1:0]   n_head [NUM_ORD];
    logic [CNT_W-1:0]    r_cnt [NUM_ORD];
    logic [CNT_W-1:0]    n_cnt [NUM_ORD];
    logic [TOT_W-1:0]    r_total, n_total;
    logic                r_func, n_func;
    logic [ORD_W-1:0]    r_need, n_need;
    logic [PAGE_W-1:0]   r_base, n_base;
    logic [ORD_W-1:0]    r_k, n_k;
    logic [PAGE_W-1:0]   r_idx, n_idx;
    logic [PAGE_W-1:0]   r_pg, n_pg;
    logic [ORD_W-1:0]    r_pk, n_pk;
    t_rec                r_unx, n_unx;
    logic [LINK_W-1:0]   r_h, n_h;
    t_uret               r_uret, n_uret;
    t_pret               r_pret, n_pret;
    t_status             r_status, n_status;
    logic [PAGE_W-1:0]   r_granted, n_granted;

    // Page record memory: one read port with registered data, one write port
    // with separate enables for the flag/order, next and prev fields.
    logic [$bits(t_rec)-1:0] mem [NPAGES];
    logic [$bits(t_rec)-1:0] rd_q;
    t_rec                    rd_rec;
    logic [PAGE_W-1:0]       rd_addr;
    logic [PAGE_W-1:0]       wa;
    t_rec                    wd;
    logic                    we_meta, we_next, we_prev;

    assign rd_rec = t_rec'(rd_q);

    always_ff @(posedge i_clk) begin
        rd_q <= mem[rd_addr];
        if (we_meta) begin
            mem[wa][30:26] <= {wd.free_head, wd.order};
        end
        if (we_next) begin
            mem[wa][25:13] <= wd.next;
        end
        if (we_prev) begin
            mem[wa][12:0] <= wd.prev;
        end
    end

    // Lowest order at or above the request that holds a free block.
    logic             found;
    logic [ORD_W-1:0] found_k;
    always_comb begin
        found   = 1'b0;
        found_k = '0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if ((ORD_W'(k) >= r_need) && (r_cnt[k] != '0)) begin
                found   = 1'b1;
                found_k = ORD_W'(k);
            end
        end
    end

    logic [ORD_W-1:0]  u_k;
    logic [ORD_W-1:0]  s_km;
    logic [12:0]       s_second;
    logic [PAGE_W-1:0] f_bud;
    logic [12:0]       cfg_arena;

    assign u_k       = (rd_rec.order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : rd_rec.order;
    assign s_km      = r_k - ORD_W'(1);
    assign s_second  = {1'b0, r_idx} + (13'd1 << s_km);
    assign f_bud     = r_idx ^ (PAGE_W'(1) << r_k);
    assign cfg_arena = (i_cfg_data > PAGE_CAP) ? PAGE_CAP : i_cfg_data;

    always_comb begin
        n_state   = r_state;
        n_arena   = r_arena;
        n_clr     = r_clr;
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_total   = r_total;
        n_func    = r_func;
        n_need    = r_need;
        n_base    = r_base;
        n_k       = r_k;
        n_idx     = r_idx;
        n_pg      = r_pg;
        n_pk      = r_pk;
        n_unx     = r_unx;
        n_h       = r_h;
        n_uret    = r_uret;
        n_pret    = r_pret;
        n_status  = r_status;
        n_granted = r_granted;
        rd_addr   = r_pg;
        wa        = r_pg;
        wd        = REC_EMPTY;
        we_meta   = 1'b0;
        we_next   = 1'b0;
        we_prev   = 1'b0;

        case (r_state)
            S_CLEAR: begin
                wa      = r_clr;
                wd      = f_init_rec(r_arena, r_clr);
                we_meta = 1'b1;
                we_next = 1'b1;
                we_prev = 1'b1;
                n_clr   = r_clr + PAGE_W'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func    = i_func;
                    n_need    = f_ceil_log2(i_page_count);
                    n_base    = i_block_start;
                    n_granted = '0;
                    n_status  = ST_OK;
                    if (i_page_count == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_DONE;
                    end else if (f_ceil_log2(i_page_count) > ORD_W'(MAX_ORDER)) begin
                        n_status = ST_BIG;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (!r_func) begin
                    if (!found || (r_head[found_k] == LINK_NONE)) begin
                        n_status = ST_NOMEM;
                        n_state  = S_DONE;
                    end else begin
                        n_k     = found_k;
                        n_idx   = r_head[found_k][PAGE_W-1:0];
                        n_pg    = r_head[found_k][PAGE_W-1:0];
                        n_uret  = UR_ALLOC;
                        n_state = S_U_RD;
                    end
                end else if ({1'b0, r_base} >= r_arena) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_base;
                    n_k     = r_need;
                    n_state = S_F_CHK;
                end
            end
            S_U_RD: begin
                rd_addr = r_pg;
                n_state = S_U_W1;
            end
            S_U_W1: begin
                n_unx = rd_rec;
                if (rd_rec.prev == LINK_NONE) begin
                    n_head[u_k] = rd_rec.next;
                end else begin
                    wa      = rd_rec.prev[PAGE_W-1:0];
                    wd.next = rd_rec.next;
                    we_next = 1'b1;
                end
                n_cnt[u_k] = r_cnt[u_k] - CNT_W'(1);
                n_total    = r_total - (TOT_W'(1) << u_k);
                n_state    = S_U_W2;
            end
            S_U_W2: begin
                if (r_unx.next != LINK_NONE) begin
                    wa      = r_unx.next[PAGE_W-1:0];
                    wd.prev = r_unx.prev;
                    we_prev = 1'b1;
                end
                n_state = S_U_W3;
            end
            S_U_W3: begin
                wa      = r_pg;
                wd      = REC_EMPTY;
                we_meta = 1'b1;
                we_next = 1'b1;
                we_prev = 1'b1;
                case (r_uret)
                    UR_ALLOC: n_state = S_SPLIT;
                    UR_PUSH:  n_state = S_P_W1;
                    UR_FREE: begin
                        n_idx   = (r_pg < r_idx) ? r_pg : r_idx;
                        n_k     = r_k + ORD_W'(1);
                        n_state = S_F_CHK;
                    end
                    default:  n_state = S_DONE;
                endcase
            end
            S_SPLIT: begin
                if (r_k > r_need) begin
                    n_k = s_km;
                    if (s_second < r_arena) begin
                        n_pg    = s_second[PAGE_W-1:0];
                        n_pk    = s_km;
                        n_pret  = PR_SPLIT;
                        n_state = S_P_RD;
                    end
                end else begin
                    n_granted = r_idx;
                    n_state   = S_DONE;
                end
            end
            S_P_RD: begin
                rd_addr = r_pg;
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                if (rd_rec.free_head) begin
                    // The page is already listed: take it off its list first.
                    n_uret  = UR_PUSH;
                    n_state = S_U_RD;
                end else begin
                    n_state = S_P_W1;
                end
            end
            S_P_W1: begin
                wa           = r_pg;
                wd.free_head = 1'b1;
                wd.order     = r_pk;
                wd.next      = r_head[r_pk];
                wd.prev      = LINK_NONE;
                we_meta      = 1'b1;
                we_next      = 1'b1;
                we_prev      = 1'b1;
                n_h          = r_head[r_pk];
                n_head[r_pk] = {1'b0, r_pg};
                n_cnt[r_pk]  = r_cnt[r_pk] + CNT_W'(1);
                n_total      = r_total + (TOT_W'(1) << r_pk);
                n_state      = S_P_W2;
            end
            S_P_W2: begin
                if (r_h != LINK_NONE) begin
                    wa      = r_h[PAGE_W-1:0];
                    wd.prev = {1'b0, r_pg};
                    we_prev = 1'b1;
                end
                n_state = (r_pret == PR_SPLIT) ? S_SPLIT : S_DONE;
            end
            S_F_CHK: begin
                if ((r_k < ORD_W'(MAX_ORDER)) && ({1'b0, f_bud} < r_arena)) begin
                    rd_addr = f_bud;
                    n_pg    = f_bud;
                    n_state = S_F_EVAL;
                end else begin
                    n_pg    = r_idx;
                    n_pk    = r_k;
                    n_pret  = PR_DONE;
                    n_state = S_P_RD;
                end
            end
            S_F_EVAL: begin
                if (rd_rec.free_head && (rd_rec.order == r_k)) begin
                    n_uret  = UR_FREE;
                    n_state = S_U_RD;
                end else begin
                    n_pg    = r_idx;
                    n_pk    = r_k;
                    n_pret  = PR_DONE;
                    n_state = S_P_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A new arena size restarts the build sweep.
        if (i_cfg_valid) begin
            n_arena = cfg_arena;
            n_clr   = '0;
            n_state = S_CLEAR;
            n_total = TOT_W'(cfg_arena);
            for (int k = 0; k < NUM_ORD; k++) begin
                n_head[k] = f_init_head(cfg_arena, k);
                n_cnt[k]  = CNT_W'(cfg_arena[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_arena <= ARENA_RESET;
            r_clr   <= '0;
            r_total <= TOT_W'(ARENA_RESET);
            for (int k = 0; k < NUM_ORD; k++) begin
                r_head[k] <= f_init_head(ARENA_RESET, k);
                r_cnt[k]  <= CNT_W'(ARENA_RESET[k]);
            end
            r_uret <= UR_ALLOC;
            r_pret <= PR_DONE;
        end else begin
            r_state <= n_state;
            r_arena <= n_arena;
            r_clr   <= n_clr;
            r_total <= n_total;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_uret  <= n_uret;
            r_pret  <= n_pret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_need    <= n_need;
        r_base    <= n_base;
        r_k       <= n_k;
        r_idx     <= n_idx;
        r_pg      <= n_pg;
        r_pk      <= n_pk;
        r_unx     <= n_unx;
        r_h       <= n_h;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = (r_state == S_DONE);
    assign o_status          = r_status;
    assign o_granted_start   = r_granted;
    assign o_free_page_total = (r_total > TOT_W'(TOTAL_SAT)) ? TOTAL_SAT
                                                             : r_total[12:0];
    assign o_cfg_ready       = 1'b1;

    // A result lasts one cycle and the block is still busy while it shows.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result strobe longer than one cycle");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy) else $error("result shown while idle");

    // A transferred request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_valid) |=> busy) else $error("request dropped");

    // Nothing is granted unless the request succeeded.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> (o_granted_start == '0))
        else $error("grant on failed request");

endmodule

FILE: dv/tb_buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free requests through the start/busy handshake over
// several arena sizes. A built-in buddy list model predicts each result, and
// each strobed result is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_buddy_page_allocator;
    import bpa_pkg::*;

    localparam int   NONE_IDX    = -1;
    localparam int   CYCLE_LIMIT = 3_000_000;
    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_FREE   = 1'b1;

    typedef struct {
        logic        func;
        logic [12:0] count;
        logic [11:0] base;
    } t_request;

    typedef struct {
        t_status     status;
        logic [11:0] granted;
        logic [12:0] total;
    } t_answer;

    typedef struct {
        int start_pg;
        int ord;
    } t_held;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_func = 1'b0;
    logic [12:0] i_page_count = '0;
    logic [11:0] i_block_start = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [11:0] o_granted_start;
    logic [12:0] o_free_page_total;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_data = '0;

    buddy_page_allocator i_dut (.*);

    // The clock toggles every half period of a 4 ns cycle.
    always #2 i_clk = ~i_clk;

    // Shadow copy of the allocator state: list heads and block counts per
    // order, plus a record for each page.
    int arena_sz;
    int list_head [NUM_ORD];
    int list_len  [NUM_ORD];
    bit pg_free   [NPAGES];
    int pg_ord    [NPAGES];
    int pg_next   [NPAGES];
    int pg_prev   [NPAGES];

    t_request pending_reqs[$];
    t_answer  due_answers[$];
    t_held    held_blocks[$];
    t_request cur_req;
    int       failures = 0;
    int       cycles = 0;
    int       burst_left = 0;
    int       gap_left = 0;

    function automatic void unlink_pg(int p);
        int k, n, v;
        k = pg_ord[p] > MAX_ORDER ? MAX_ORDER : pg_ord[p];
        n = pg_next[p];
        v = pg_prev[p];
        if (v == NONE_IDX) list_head[k] = n;
        else pg_next[v] = n;
        if (n != NONE_IDX) pg_prev[n] = v;
        list_len[k]--;
        pg_free[p] = 1'b0;
        pg_ord[p]  = 0;
        pg_next[p] = NONE_IDX;
        pg_prev[p] = NONE_IDX;
    endfunction

    // A page that is already a free head (double or overlapping free) is
    // first taken off its old list so that every list stays consistent.
    function automatic void push_pg(int k, int p);
        int h;
        if (pg_free[p]) unlink_pg(p);
        h = list_head[k];
        pg_free[p] = 1'b1;
        pg_ord[p]  = k;
        pg_prev[p] = NONE_IDX;
        pg_next[p] = h;
        if (h != NONE_IDX) pg_prev[h] = p;
        list_head[k] = p;
        list_len[k]++;
    endfunction

    // Greedy aligned split of the arena, walking up from page 0.
    function automatic void build_lists(int pages);
        int i, best;
        arena_sz = pages > NPAGES ? NPAGES : pages;
        for (int k = 0; k < NUM_ORD; k++) begin
            list_head[k] = NONE_IDX;
            list_len[k]  = 0;
        end
        for (int p = 0; p < NPAGES; p++) begin
            pg_free[p] = 1'b0;
            pg_ord[p]  = 0;
            pg_next[p] = NONE_IDX;
            pg_prev[p] = NONE_IDX;
        end
        i = 0;
        while (i < arena_sz) begin
            best = 0;
            for (int k = 0; k < NUM_ORD; k++) begin
                if ((1 << k) > arena_sz - i) break;
                if ((i & ((1 << k) - 1)) == 0) best = k;
            end
            push_pg(best, i);
            i += 1 << best;
        end
    endfunction

    function automatic int order_for(int n);
        int k;
        k = 0;
        while ((1 << k) < n) k++;
        return k;
    endfunction

    // Applies one request to the shadow state and returns the result it gives.
    function automatic t_answer serve_request(t_request r);
        t_answer a;
        int need, k, idx, bud, total;
        a.status  = ST_OK;
        a.granted = '0;
        need = order_for(int'(r.count));
        if (r.count == 0) begin
            a.status = ST_ZERO;
        end else if (need > MAX_ORDER) begin
            a.status = ST_BIG;
        end else if (r.func == FUNC_ALLOC) begin
            k = need;
            while (k <= MAX_ORDER && list_len[k] == 0) k++;
            if (k > MAX_ORDER || list_head[k] == NONE_IDX) begin
                a.status = ST_NOMEM;
            end else begin
                idx = list_head[k];
                unlink_pg(idx);
                // Upper halves past the arena only appear after bogus frees.
                while (k > need) begin
                    k--;
                    if (idx + (1 << k) < arena_sz) push_pg(k, idx + (1 << k));
                end
                a.granted = idx[11:0];
                held_blocks.push_back('{idx, need});
            end
        end else if (int'(r.base) >= arena_sz) begin
            a.status = ST_NOMEM;
        end else begin
            idx = int'(r.base);
            k = need;
            while (k < MAX_ORDER) begin
                bud = idx ^ (1 << k);
                if (bud >= arena_sz || !(pg_free[bud] && pg_ord[bud] == k)) break;
                unlink_pg(bud);
                if (bud < idx) idx = bud;
                k++;
            end
            push_pg(k, idx);
        end
        total = 0;
        for (int j = 0; j < NUM_ORD; j++) total += list_len[j] << j;
        a.total = total > 8191 ? TOTAL_SAT : total[12:0];
        return a;
    endfunction

    // Driver: a request is transferred at an edge with start high and busy
    // low. The sender runs in bursts of random length separated by gaps.
    always @(posedge i_clk) begin
        logic nxt_start;
        nxt_start = start;
        if (i_rst_n) begin
            if (start && !busy) begin
                due_answers.push_back(serve_request(cur_req));
                nxt_start = 1'b0;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_func        <= cur_req.func;
                    i_page_count  <= cur_req.count;
                    i_block_start <= cur_req.base;
                    nxt_start = 1'b1;
                end
            end
        end
        start <= nxt_start;
    end

    // Monitor: every strobe is a result that must match the oldest prediction.
    always @(posedge i_clk) begin
        t_answer e;
        cycles++;
        if (i_rst_n && o_strobe) begin
            if (due_answers.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d start %0d total %0d",
                         $time, o_status, o_granted_start, o_free_page_total);
                failures++;
            end else begin
                e = due_answers.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    failures++;
                end
                if (o_granted_start !== e.granted) begin
                    $display("%0t: granted_start expected %0d actual %0d",
                             $time, e.granted, o_granted_start);
                    failures++;
                end
                if (o_free_page_total !== e.total) begin
                    $display("%0t: free_page_total expected %0d actual %0d",
                             $time, e.total, o_free_page_total);
                    failures++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(logic f, int n, int b);
        t_request r;
        r.func  = f;
        r.count = n[12:0];
        r.base  = b[11:0];
        pending_reqs.push_back(r);
    endtask

    // Holds the feed back until the block has answered everything, which
    // also serves as the idle point for configuration writes.
    task automatic drain();
        while (pending_reqs.size() > 0 || start || due_answers.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_arena(int pages);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pages[12:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        build_lists(pages);
        // Give busy time to rise for the record sweep before any request.
        repeat (8) @(posedge i_clk);
    endtask

    // Random traffic built from the live list of granted blocks, mostly
    // allocate/free pairs with some malformed and duplicate requests mixed in.
    task automatic random_traffic(int n_items);
        t_held h;
        int sel, pick;
        for (int i = 0; i < n_items; i++) begin
            while (pending_reqs.size() > 0) @(posedge i_clk);
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send(FUNC_ALLOC, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096)
                                 : $urandom_range(1, 1 << $urandom_range(0, 6)), 0);
            end else if (sel < 85 && held_blocks.size() > 0) begin
                pick = $urandom_range(0, held_blocks.size() - 1);
                h = held_blocks[pick];
                held_blocks.delete(pick);
                send(FUNC_FREE, $urandom_range((1 << h.ord) / 2 + 1, 1 << h.ord),
                     h.start_pg);
            end else if (sel < 92 && held_blocks.size() > 0) begin
                // Double or overlapping free of a block that may already be free.
                h = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
                send(FUNC_FREE, 1 << $urandom_range(0, h.ord), h.start_pg);
            end else begin
                send(1'($urandom_range(0, 1)), $urandom_range(0, 8191),
                     $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        int arenas[8];
        arenas = '{4096, 1, 0, 8191, 4095, 13, 300, 4096};
        build_lists(int'(ARENA_RESET));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (8) @(posedge i_clk);

        // Directed: error codes, field extremes and whole-arena traffic.
        send(FUNC_ALLOC, 0, 0);
        send(FUNC_FREE, 0, 4095);
        send(FUNC_ALLOC, 8191, 0);
        send(FUNC_FREE, 4097, 0);
        send(FUNC_ALLOC, 4096, 0);
        send(FUNC_ALLOC, 1, 0);
        send(FUNC_FREE, 4096, 0);
        send(FUNC_ALLOC, 1, 0);
        send(FUNC_ALLOC, 3, 0);
        send(FUNC_ALLOC, 2048, 0);
        send(FUNC_FREE, 1, 0);
        send(FUNC_FREE, 4, 4);
        send(FUNC_FREE, 1, 4095);
        send(FUNC_FREE, 1, 4095);
        send(FUNC_FREE, 2, 4094);
        send(FUNC_FREE, 3, 5);
        send(FUNC_FREE, 2048, 2048);
        send(FUNC_FREE, 4096, 2730);
        send(FUNC_ALLOC, 4096, 0);
        send(FUNC_FREE, 4096, 0);
        drain();
        held_blocks.delete();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) write_arena(arenas[ph]);
            held_blocks.delete();
            random_traffic(ph == 0 ? 330 : 160);
            drain();
        end
        // An out-of-range free and an allocate on an empty arena after the last rebuild.
        write_arena(0);
        send(FUNC_FREE, 1, 0);
        send(FUNC_ALLOC, 1, 0);
        drain();

        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
